// ===== hw/rtl/whf_pkg.sv =====
`timescale 1ns / 1ps
package whf_pkg;

   localparam int MAX_WAYPOINTS_DEF = 64;
   localparam int CORDIC_STEPS_DEF  = 16;
   localparam int TABLE_LEN         = 24;

   // cordic datapath width, covers gain and pre-turn of the widest vector
   localparam int CW = 38;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_ARRIVE_RADIUS     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HEADING_TOLERANCE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FAST_SPEED        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOW_SPEED        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_HEADING_GAIN      = 3'd4;

   localparam logic [30:0] ARRIVE_RADIUS_RST     = 31'd19661;
   localparam logic [14:0] HEADING_TOLERANCE_RST = 15'd4915;
   localparam logic [15:0] FAST_SPEED_RST        = 16'd1638;
   localparam logic [15:0] SLOW_SPEED_RST        = 16'd205;
   localparam logic [11:0] HEADING_GAIN_RST      = 12'd384;

   localparam logic signed [17:0] ANG_PI      = 18'sd25736;
   localparam logic signed [17:0] ANG_TWO_PI  = 18'sd51472;
   localparam logic signed [15:0] ANG_HALF_PI = 16'sd12868;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_ODOM   = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_NO_PATH  = 3'd0,
      ST_REACHED  = 3'd1,
      ST_COMMAND  = 3'd2,
      ST_POSE     = 3'd3,
      ST_CLEARED  = 3'd4,
      ST_STORED   = 3'd5,
      ST_DROPPED  = 3'd6
   } status_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] waypoint_x;
      logic signed [31:0] waypoint_y;
      logic signed [31:0] robot_x;
      logic signed [31:0] robot_y;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } item_type;

   typedef struct packed {
      logic [30:0] arrive_radius;
      logic [14:0] heading_tolerance;
      logic [15:0] fast_speed;
      logic [15:0] slow_speed;
      logic [11:0] heading_gain;
   } cfg_type;

   typedef struct packed {
      logic               command_valid;
      logic [15:0]        linear_speed;
      logic signed [15:0] angular_rate;
      status_type         status;
   } result_type;

   function automatic logic signed [15:0] atan_entry(input logic [4:0] i);
      logic signed [15:0] a;
      unique case (i)
         5'd0:  a = 16'sd6434;
         5'd1:  a = 16'sd3798;
         5'd2:  a = 16'sd2007;
         5'd3:  a = 16'sd1019;
         5'd4:  a = 16'sd511;
         5'd5:  a = 16'sd256;
         5'd6:  a = 16'sd128;
         5'd7:  a = 16'sd64;
         5'd8:  a = 16'sd32;
         5'd9:  a = 16'sd16;
         5'd10: a = 16'sd8;
         5'd11: a = 16'sd4;
         5'd12: a = 16'sd2;
         5'd13: a = 16'sd1;
         default: a = 16'sd0;
      endcase
      return a;
   endfunction

endpackage

// ===== hw/rtl/waypoint_heading_follower_top.sv =====
`timescale 1ns / 1ps
// waypoint heading follower: keeps a path of up to MAX_WAYPOINTS waypoints, a
// target index and the latest pose, and answers every request item with exactly
// one response item. tuser carries the operation (clear, append, odometry,
// tick). odometry and a tick that steers wait on the iterative cordic in the back
// end, one micro-rotation per cycle; clear, append and a tick that reaches or
// finds no target do not use it. a two-entry request queue and the response
// register let both sides stall on their own. waypoints are kept in a memory
// with no reset, so a tick after clear reads only entries appended since.
// write registers only while idle.
module waypoint_heading_follower_top #(
   parameter int MAX_WAYPOINTS = whf_pkg::MAX_WAYPOINTS_DEF,
   parameter int CORDIC_STEPS  = whf_pkg::CORDIC_STEPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // waypoint_x, waypoint_y, robot_x, robot_y, quat_x, quat_y, quat_z, quat_w
   input  logic [191:0]                       req_tdata,
   // operation
   input  logic [1:0]                         req_tuser,
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // linear_speed, angular_rate
   output logic [31:0]                        rsp_tdata,
   // command_valid, status
   output logic [3:0]                         rsp_tuser,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [whf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [whf_pkg::CSR_DATA_W-1:0]     csr_data
);

   whf_pkg::cfg_type    cfg_ff, cfg_in;
   whf_pkg::item_type   q_item;
   whf_pkg::result_type result;
   logic                q_valid, q_pop;

   // registers always take a write at once
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            whf_pkg::REG_ARRIVE_RADIUS:     cfg_in.arrive_radius     = csr_data[30:0];
            whf_pkg::REG_HEADING_TOLERANCE: cfg_in.heading_tolerance = csr_data[14:0];
            whf_pkg::REG_FAST_SPEED:        cfg_in.fast_speed        = csr_data[15:0];
            whf_pkg::REG_SLOW_SPEED:        cfg_in.slow_speed        = csr_data[15:0];
            whf_pkg::REG_HEADING_GAIN:      cfg_in.heading_gain      = csr_data[11:0];
            default:                        cfg_in = cfg_ff; // unmapped index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.arrive_radius     <= whf_pkg::ARRIVE_RADIUS_RST;
         cfg_ff.heading_tolerance <= whf_pkg::HEADING_TOLERANCE_RST;
         cfg_ff.fast_speed        <= whf_pkg::FAST_SPEED_RST;
         cfg_ff.slow_speed        <= whf_pkg::SLOW_SPEED_RST;
         cfg_ff.heading_gain      <= whf_pkg::HEADING_GAIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: unpacks and queues request items
   whf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_op    (req_tuser),
      .in_data  (req_tdata),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_item   (q_item)
   );

   // back end: path store, pose, cordic and steering math
   whf_back #(
      .MAX_WAYPOINTS (MAX_WAYPOINTS),
      .CORDIC_STEPS  (CORDIC_STEPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {result.angular_rate, result.linear_speed};
   assign rsp_tuser = {result.status, result.command_valid};

endmodule

// ===== hw/rtl/whf_front.sv =====
`timescale 1ns / 1ps
module whf_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [1:0]         in_op,
   input  logic [191:0]       in_data,
   output logic               q_valid,
   input  logic               q_pop,
   output whf_pkg::item_type  q_item
);

   whf_pkg::item_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   whf_pkg::item_type decoded;
   logic              push, pop;

   // split the bus into fields, kind comes from tuser
   always_comb begin
      decoded.op         = whf_pkg::op_type'(in_op);
      decoded.waypoint_x = in_data[31:0];
      decoded.waypoint_y = in_data[63:32];
      decoded.robot_x    = in_data[95:64];
      decoded.robot_y    = in_data[127:96];
      decoded.quat_x     = in_data[143:128];
      decoded.quat_y     = in_data[159:144];
      decoded.quat_z     = in_data[175:160];
      decoded.quat_w     = in_data[191:176];
   end

   assign in_ready = (count_ff != 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = entry_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== hw/rtl/whf_cordic.sv =====
`timescale 1ns / 1ps
module whf_cordic #(
   parameter int CORDIC_STEPS = whf_pkg::CORDIC_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [whf_pkg::CW-1:0] x_in,
   input  logic signed [whf_pkg::CW-1:0] y_in,
   output logic                          done,
   output logic signed [15:0]            angle
);

   localparam int ITERS = (CORDIC_STEPS < whf_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                               : whf_pkg::TABLE_LEN;
   localparam int IW = $clog2(ITERS);

   logic signed [whf_pkg::CW-1:0] x_ff, x_in_nx, y_ff, y_in_nx;
   logic signed [15:0]            z_ff, z_in;
   logic [IW-1:0]                 cnt_ff, cnt_in;
   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic                          zero_ff, zero_in;
   logic signed [whf_pkg::CW-1:0] xs, ys;
   logic signed [15:0]            step_angle;
   logic                          last;

   assign xs         = x_ff >>> cnt_ff;
   assign ys         = y_ff >>> cnt_ff;
   assign step_angle = whf_pkg::atan_entry(5'(cnt_ff));
   assign last       = (cnt_ff == IW'(ITERS - 1));

   always_comb begin
      x_in_nx = x_ff;
      y_in_nx = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      if (start) begin
         // quarter turn into the right half plane first
         zero_in = (x_in == '0) && (y_in == '0);
         run_in  = 1'b1;
         cnt_in  = '0;
         if (x_in < 0) begin
            if (y_in >= 0) begin
               x_in_nx = y_in;
               y_in_nx = -x_in;
               z_in    = whf_pkg::ANG_HALF_PI;
            end else begin
               x_in_nx = -y_in;
               y_in_nx = x_in;
               z_in    = -whf_pkg::ANG_HALF_PI;
            end
         end else begin
            x_in_nx = x_in;
            y_in_nx = y_in;
            z_in    = '0;
         end
      end else if (run_ff) begin
         if (y_ff > 0) begin
            x_in_nx = x_ff + ys;
            y_in_nx = y_ff - xs;
            z_in    = z_ff + step_angle;
         end else begin
            x_in_nx = x_ff - ys;
            y_in_nx = y_ff + xs;
            z_in    = z_ff - step_angle;
         end
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in_nx;
      y_ff    <= y_in_nx;
      z_ff    <= z_in;
      cnt_ff  <= cnt_in;
      zero_ff <= zero_in;
   end

   assign done  = done_ff;
   assign angle = zero_ff ? 16'sd0 : z_ff;

endmodule

// ===== hw/rtl/whf_back.sv =====
`timescale 1ns / 1ps
module whf_back #(
   parameter int MAX_WAYPOINTS = whf_pkg::MAX_WAYPOINTS_DEF,
   parameter int CORDIC_STEPS  = whf_pkg::CORDIC_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  whf_pkg::cfg_type      cfg,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  whf_pkg::item_type     q_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output whf_pkg::result_type   out_result
);

   localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
   localparam int LW = $clog2(MAX_WAYPOINTS + 1);
   localparam int CW = whf_pkg::CW;

   typedef enum logic [11:0] {
      S_IDLE       = 12'b000000000001,
      S_ODO_SUM    = 12'b000000000010,
      S_ODO_WAIT   = 12'b000000000100,
      S_TICK_DIFF  = 12'b000000001000,
      S_TICK_SQ    = 12'b000000010000,
      S_TICK_CMP   = 12'b000000100000,
      S_ANGLE_WAIT = 12'b000001000000,
      S_TURN_MUL   = 12'b000010000000,
      S_TURN_SAT   = 12'b000100000000,
      S_EMIT       = 12'b001000000000,
      S_SPARE_A    = 12'b010000000000,
      S_SPARE_B    = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   logic [63:0] path_mem [MAX_WAYPOINTS];
   logic [63:0] rd_ff;

   logic [LW-1:0]      len_ff, len_in, tgt_ff, tgt_in;
   logic signed [31:0] pose_x_ff, pose_x_in, pose_y_ff, pose_y_in;
   logic signed [15:0] heading_ff, heading_in;

   logic signed [31:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic [61:0]        sqx_ff, sqy_ff, r2_ff;
   logic               inrange_ff;
   logic signed [16:0] err_ff, err_in;
   logic signed [29:0] prod_ff;
   logic [15:0]        lin_ff, lin_in;

   whf_pkg::result_type res_ff, res_in, out_ff;
   logic                out_valid_ff, out_valid_in;

   logic                 mem_we;
   logic                 cordic_start, cordic_done;
   logic signed [CW-1:0] cordic_x, cordic_y;
   logic signed [15:0]   cordic_angle;

   logic signed [33:0] num;
   logic signed [34:0] den;
   logic [32:0]        abs_dx, abs_dy;
   logic [62:0]        d2;
   logic signed [17:0] diff;
   logic [15:0]        mag;
   logic signed [30:0] rounded;
   logic signed [15:0] sat;
   logic               out_free;

   whf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .x_in  (cordic_x),
      .y_in  (cordic_y),
      .done  (cordic_done),
      .angle (cordic_angle)
   );

   // yaw vector at Q2.28
   assign num = 34'(pa_ff + pb_ff) <<< 1;
   assign den = 35'sd268435456 - (35'({2'b00, 32'(pc_ff)} + {2'b00, 32'(pd_ff)}) <<< 1);

   assign abs_dx = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
   assign abs_dy = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
   assign d2     = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   assign diff    = {{2{cordic_angle[15]}}, cordic_angle} - {{2{heading_ff[15]}}, heading_ff};
   assign mag     = err_ff[16] ? 16'(-err_ff) : 16'(err_ff);
   assign rounded = (31'(prod_ff) + 31'sd256) >>> 9;
   assign sat     = (rounded > 31'sd32767)  ? 16'sh7fff :
                    (rounded < -31'sd32768) ? 16'sh8000 : 16'(rounded);

   assign out_free = !out_valid_ff || out_ready;
   assign q_pop    = (state_ff == S_IDLE) && q_valid;
   assign mem_we   = q_pop && (q_item.op == whf_pkg::OP_APPEND) &&
                     (len_ff < LW'(MAX_WAYPOINTS));

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      tgt_in       = tgt_ff;
      pose_x_in    = pose_x_ff;
      pose_y_in    = pose_y_ff;
      heading_in   = heading_ff;
      err_in       = err_ff;
      lin_in       = lin_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && !out_ready;
      cordic_start = 1'b0;
      cordic_x     = CW'(num);
      cordic_y     = CW'(den);
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               res_in = '{command_valid: 1'b0, linear_speed: 16'd0,
                          angular_rate: 16'sd0, status: whf_pkg::ST_NO_PATH};
               unique case (q_item.op)
                  whf_pkg::OP_CLEAR: begin
                     len_in        = '0;
                     tgt_in        = '0;
                     res_in.status = whf_pkg::ST_CLEARED;
                     state_in      = S_EMIT;
                  end
                  whf_pkg::OP_APPEND: begin
                     if (mem_we) begin
                        len_in        = len_ff + 1'b1;
                        res_in.status = whf_pkg::ST_STORED;
                     end else begin
                        res_in.status = whf_pkg::ST_DROPPED;
                     end
                     state_in = S_EMIT;
                  end
                  whf_pkg::OP_ODOM: begin
                     pose_x_in = q_item.robot_x;
                     pose_y_in = q_item.robot_y;
                     state_in  = S_ODO_SUM;
                  end
                  whf_pkg::OP_TICK: begin
                     // no path or every waypoint passed
                     state_in = (tgt_ff >= len_ff) ? S_EMIT : S_TICK_DIFF;
                  end
                  default: state_in = S_EMIT;
               endcase
            end
         end
         S_ODO_SUM: begin
            cordic_start = 1'b1;
            cordic_x     = CW'(den);
            cordic_y     = CW'(num);
            state_in     = S_ODO_WAIT;
         end
         S_ODO_WAIT: begin
            if (cordic_done) begin
               heading_in    = cordic_angle;
               res_in.status = whf_pkg::ST_POSE;
               state_in      = S_EMIT;
            end
         end
         S_TICK_DIFF: state_in = S_TICK_SQ;
         S_TICK_SQ:   state_in = S_TICK_CMP;
         S_TICK_CMP: begin
            if (inrange_ff && (d2 < {1'b0, r2_ff})) begin
               tgt_in        = tgt_ff + 1'b1;
               res_in.status = whf_pkg::ST_REACHED;
               state_in      = S_EMIT;
            end else begin
               cordic_start = 1'b1;
               cordic_x     = CW'(dx_ff);
               cordic_y     = CW'(dy_ff);
               state_in     = S_ANGLE_WAIT;
            end
         end
         S_ANGLE_WAIT: begin
            if (cordic_done) begin
               // one wrap suffices, both angles lie well inside one turn
               if (diff > whf_pkg::ANG_PI) begin
                  err_in = 17'(diff - whf_pkg::ANG_TWO_PI);
               end else if (diff < -whf_pkg::ANG_PI) begin
                  err_in = 17'(diff + whf_pkg::ANG_TWO_PI);
               end else begin
                  err_in = 17'(diff);
               end
               state_in = S_TURN_MUL;
            end
         end
         S_TURN_MUL: begin
            lin_in   = (mag < {1'b0, cfg.heading_tolerance}) ? cfg.fast_speed
                                                              : cfg.slow_speed;
            state_in = S_TURN_SAT;
         end
         S_TURN_SAT: begin
            res_in = '{command_valid: 1'b1, linear_speed: lin_ff,
                       angular_rate: sat, status: whf_pkg::ST_COMMAND};
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         tgt_ff       <= '0;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         heading_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         tgt_ff       <= tgt_in;
         pose_x_ff    <= pose_x_in;
         pose_y_ff    <= pose_y_in;
         heading_ff   <= heading_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff  <= err_in;
      lin_ff  <= lin_in;
      res_ff  <= res_in;
      pa_ff   <= q_item.quat_w * q_item.quat_z;
      pb_ff   <= q_item.quat_x * q_item.quat_y;
      pc_ff   <= q_item.quat_y * q_item.quat_y;
      pd_ff   <= q_item.quat_z * q_item.quat_z;
      dx_ff   <= 33'(signed'(rd_ff[31:0])) - 33'(pose_x_ff);
      dy_ff   <= 33'(signed'(rd_ff[63:32])) - 33'(pose_y_ff);
      sqx_ff  <= abs_dx[30:0] * abs_dx[30:0];
      sqy_ff  <= abs_dy[30:0] * abs_dy[30:0];
      r2_ff   <= cfg.arrive_radius * cfg.arrive_radius;
      inrange_ff <= (abs_dx[32:31] == 2'b00) && (abs_dy[32:31] == 2'b00);
      prod_ff <= $signed({1'b0, cfg.heading_gain}) * err_ff;
      if (state_ff == S_EMIT && out_free) begin
         out_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         path_mem[len_ff[AW-1:0]] <= {q_item.waypoint_y, q_item.waypoint_x};
      end
      rd_ff <= path_mem[tgt_ff[AW-1:0]];
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

endmodule
